>>> sv/bls_pkg.sv
// ============================================================================
// bls_pkg
// Shared types, codes and defaults for the line stepper.
// ============================================================================
package bls_pkg;

    // default coordinate width of the stepper datapath
    localparam int COORD_BITS_DEF = 16;

    // queue depths (powers of two)
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // register file
    localparam int REG_ADDR_BITS = 1;
    localparam int REG_DATA_BITS = 15;
    localparam logic [REG_ADDR_BITS-1:0] REG_SURFACE_WIDTH  = 1'b0;
    localparam logic [REG_ADDR_BITS-1:0] REG_SURFACE_HEIGHT = 1'b1;
    localparam logic [REG_DATA_BITS-1:0] SURFACE_WIDTH_RST  = 15'd1024;
    localparam logic [REG_DATA_BITS-1:0] SURFACE_HEIGHT_RST = 15'd768;

    // transaction kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               inside_res;
        logic               last;
    } out_item_t;

    // width of the decoded command word for a given coordinate width:
    // kind, four coordinates, two signs, two deltas and the initial error
    function automatic int cmd_bits(input int c);
        return 7 * c + 8;
    endfunction

endpackage

>>> sv/bls_fifo.sv
// ============================================================================
// bls_fifo
// Small first-word-fall-through queue with push/full and pop/empty.
// ============================================================================
module bls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // occupancy never runs past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue occupancy above depth");

    // write and read pointers coincide when full
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("full queue with mismatched pointers");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue flagged full and empty together");

endmodule

>>> sv/bls_front.sv
// ============================================================================
// bls_front
// Decodes incoming transactions: endpoint extraction, deltas, step signs
// and the initial error term for start transactions.
// ============================================================================
module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  bls_pkg::in_item_t                         item,
    output logic [bls_pkg::cmd_bits(COORD_BITS)-1:0]  cmd
);

    import bls_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = C + 1;
    localparam int EW = C + 3;

    typedef struct packed {
        logic                 kind;
        logic signed [C-1:0]  x1;
        logic signed [C-1:0]  y1;
        logic signed [C-1:0]  x2;
        logic signed [C-1:0]  y2;
        logic                 dxn;
        logic                 dyn;
        logic [AW-1:0]        adx;
        logic [AW-1:0]        ady;
        logic signed [EW-1:0] err;
    } cmd_t;

    // field bits taken as a C-bit pattern: truncated when narrower,
    // zero-padded when wider
    function automatic logic [C-1:0] to_coord(input logic [15:0] v);
        logic [C+15:0] wide;
        wide = {{C{1'b0}}, v};
        return wide[C-1:0];
    endfunction

    cmd_t            c_w;
    logic [AW-1:0]   dx, dy;
    logic            dx_pos, dy_pos;

    always_comb
    begin
        c_w      = '0;
        c_w.kind = item.kind;
        c_w.x1   = to_coord(item.start_x);
        c_w.y1   = to_coord(item.start_y);
        c_w.x2   = to_coord(item.end_x);
        c_w.y2   = to_coord(item.end_y);
        dx       = {c_w.x2[C-1], c_w.x2} - {c_w.x1[C-1], c_w.x1};
        dy       = {c_w.y2[C-1], c_w.y2} - {c_w.y1[C-1], c_w.y1};
        dx_pos   = !dx[AW-1] && (dx != '0);
        dy_pos   = !dy[AW-1] && (dy != '0);
        c_w.dxn  = !dx_pos;
        c_w.dyn  = !dy_pos;
        c_w.adx  = dx_pos ? dx : -dx;
        c_w.ady  = dy_pos ? dy : -dy;
        c_w.err  = {2'b00, c_w.adx} - {2'b00, c_w.ady};
    end

    assign cmd = c_w;

endmodule

>>> sv/bls_back.sv
// ============================================================================
// bls_back
// Line stepper: holds the line state and surface registers, emits one
// pixel per step while a line is active, advancing by the error-term rule.
// ============================================================================
module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [bls_pkg::REG_ADDR_BITS-1:0]         cfg_addr,
    input  logic [bls_pkg::REG_DATA_BITS-1:0]         cfg_wdata,
    input  logic [bls_pkg::cmd_bits(COORD_BITS)-1:0]  cmd,
    input  logic                                      cmd_empty,
    output logic                                      cmd_pop,
    output bls_pkg::out_item_t                        res,
    output logic                                      res_push,
    input  logic                                      res_full
);

    import bls_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = C + 1;
    localparam int EW = C + 3;

    typedef struct packed {
        logic                 kind;
        logic signed [C-1:0]  x1;
        logic signed [C-1:0]  y1;
        logic signed [C-1:0]  x2;
        logic signed [C-1:0]  y2;
        logic                 dxn;
        logic                 dyn;
        logic [AW-1:0]        adx;
        logic [AW-1:0]        ady;
        logic signed [EW-1:0] err;
    } cmd_t;

    cmd_t                 c_w;
    logic [C-1:0]         cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [C-1:0]         tgt_x_reg, tgt_x_next, tgt_y_reg, tgt_y_next;
    logic                 dxn_reg, dxn_next, dyn_reg, dyn_next;
    logic [AW-1:0]        adx_reg, adx_next, ady_reg, ady_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic                 active_reg, active_next;
    logic [REG_DATA_BITS-1:0] width_reg, height_reg;

    logic                 go;
    logic                 is_last, on_surface;
    logic signed [EW:0]   e2;
    logic                 step_x, step_y;
    logic [C+15:0]        ext_x, ext_y;

    assign c_w      = cmd_t'(cmd);
    assign go       = !cmd_empty && !res_full;
    assign cmd_pop  = go;
    assign res_push = go && (c_w.kind == KIND_STEP) && active_reg;

    // pixel classification
    assign is_last    = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign on_surface = !cur_x_reg[C-1] && !cur_y_reg[C-1]
                  && ({{REG_DATA_BITS{1'b0}}, cur_x_reg} < {{C{1'b0}}, width_reg})
                  && ({{REG_DATA_BITS{1'b0}}, cur_y_reg} < {{C{1'b0}}, height_reg});
    assign ext_x   = {{16{cur_x_reg[C-1]}}, cur_x_reg};
    assign ext_y   = {{16{cur_y_reg[C-1]}}, cur_y_reg};

    always_comb
    begin
        res.pixel_x    = ext_x[15:0];
        res.pixel_y    = ext_y[15:0];
        res.inside_res = on_surface;
        res.last       = is_last;
    end

    // error-term rule
    assign e2     = {err_reg, 1'b0};
    assign step_x = e2 > -$signed({3'b000, ady_reg});
    assign step_y = e2 < $signed({3'b000, adx_reg});

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dxn_next    = dxn_reg;
        dyn_next    = dyn_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        err_next    = err_reg;
        active_next = active_reg;
        if (go && (c_w.kind == KIND_START))
        begin
            cur_x_next  = c_w.x1;
            cur_y_next  = c_w.y1;
            tgt_x_next  = c_w.x2;
            tgt_y_next  = c_w.y2;
            dxn_next    = c_w.dxn;
            dyn_next    = c_w.dyn;
            adx_next    = c_w.adx;
            ady_next    = c_w.ady;
            err_next    = c_w.err;
            active_next = 1'b1;
        end
        else if (res_push)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_reg
                         + (step_y ? {2'b00, adx_reg} : '0)
                         - (step_x ? {2'b00, ady_reg} : '0);
                if (step_x)
                begin
                    cur_x_next = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (step_y)
                begin
                    cur_y_next = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dxn_reg    <= 1'b0;
            dyn_reg    <= 1'b0;
            adx_reg    <= '0;
            ady_reg    <= '0;
            err_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dxn_reg    <= dxn_next;
            dyn_reg    <= dyn_next;
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            err_reg    <= err_next;
            active_reg <= active_next;
        end
    end

    // surface registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SURFACE_WIDTH_RST;
            height_reg <= SURFACE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SURFACE_WIDTH:  width_reg  <= cfg_wdata;
                REG_SURFACE_HEIGHT: height_reg <= cfg_wdata;
                default:            width_reg  <= width_reg;
            endcase
        end
    end

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (c_w.kind == KIND_START)) |=> active_reg)
        else $error("start transaction did not arm the stepper");

    a_last_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && is_last) |=> !active_reg)
        else $error("stepper still active after final pixel");

    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !is_last) |-> (step_x || step_y))
        else $error("step transaction without any movement");

endmodule

>>> sv/bresenham_line_stepper_top.sv
// ============================================================================
// bresenham_line_stepper_top
// Bresenham line rasteriser with queue-style ports and a surface bounds flag.
// ============================================================================
// Path: a step transaction waits in the command queue, and its pixel is
//   written into the result queue, from which it shows on the result ports.
// Throughput: one transaction per clock while the result queue has room;
//   start transactions, and steps with no line active, give no result.
// Reset: rst_n clears the queues and the line state (no line active);
//   surface width and height return to 1024 and 768.
module bresenham_line_stepper_top #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input side, queue-style
    input  logic                              push,
    input  bls_pkg::in_item_t                 item,
    output logic                              full,
    // result side, queue-style
    output logic                              empty,
    output bls_pkg::out_item_t                result,
    input  logic                              pop,
    // register write port
    input  logic                              cfg_we,
    input  logic [bls_pkg::REG_ADDR_BITS-1:0] cfg_addr,
    input  logic [bls_pkg::REG_DATA_BITS-1:0] cfg_wdata
);

    import bls_pkg::*;

    localparam int CMD_W = cmd_bits(COORD_BITS);
    localparam int RES_W = $bits(out_item_t);

    // decoded command from the front end, and the queued copy the back
    // end works on
    logic [CMD_W-1:0] cmd_in, cmd_head;
    logic             cmd_empty, cmd_pop;

    // result word from the stepper into the output queue
    out_item_t        res_w;
    logic             res_push, res_full;
    logic [RES_W-1:0] res_rdata;

    // Front: classifies each transaction and, for a start, works out the
    // deltas, step signs and initial error before queueing it.
    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .item (item),
        .cmd  (cmd_in)
    );

    // Command queue decouples the input handshake from the stepper, so a
    // stalled result side never blocks acceptance until the queue fills.
    bls_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_head),
        .empty (cmd_empty)
    );

    // Back: holds the line, emits one pixel per step while a line is active and advances it.
    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_w),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue: the output register stage; the stepper keeps running
    // while finished pixels wait to be popped, until the queue fills.
    bls_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_w),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = out_item_t'(res_rdata);

endmodule

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the Bresenham line stepper. A driver feeds line
// starts and step transactions from a queue; each accepted transaction is run
// through a local line tracer, and a monitor compares every popped pixel with
// the oldest traced one. Phases vary surface size and both sides' idling.
// ============================================================================
module tb_top;
    import bls_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;  // far above the slowest correct run
    localparam int SETTLE_CYCLES = 8;       // covers start/ignored-step latency
    localparam int HOLD_CYCLES   = 300;     // receiver hold-off in the squeeze

    // clock, reset and block ports; everything known from time zero
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    in_item_t line_cmd = '0;
    logic full;
    logic empty;
    out_item_t pixel_out;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [REG_ADDR_BITS-1:0] cfg_addr = REG_SURFACE_WIDTH;
    logic [REG_DATA_BITS-1:0] cfg_wdata = '0;

    // transactions waiting to be offered, and pixels still owed by the block
    in_item_t pending_cmds[$];
    out_item_t pixels_due[$];

    // idling controls, percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 1'b0;
    logic rx_hold = 1'b0;

    int mismatches = 0;
    int cycle_count = 0;

    // tracer's copy of the surface registers and the line state
    logic [REG_DATA_BITS-1:0] surf_w = SURFACE_WIDTH_RST;
    logic [REG_DATA_BITS-1:0] surf_h = SURFACE_HEIGHT_RST;
    logic signed [15:0] line_x = '0;
    logic signed [15:0] line_y = '0;
    logic signed [15:0] goal_x = '0;
    logic signed [15:0] goal_y = '0;
    logic step_x_neg = 1'b0;
    logic step_y_neg = 1'b0;
    logic [16:0] span_x = '0;
    logic [16:0] span_y = '0;
    logic signed [18:0] err_acc = '0;
    logic line_live = 1'b0;

    always #10 clk = ~clk;

    bresenham_line_stepper_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (line_cmd),
        .full      (full),
        .empty     (empty),
        .result    (pixel_out),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Line tracer: a start loads the endpoints, a step emits the current pixel
    // and moves along the error-term rule. Steps with no line live are dropped.
    // ------------------------------------------------------------------------
    function automatic void trace_pixel(input in_item_t cmd);
        int dx;
        int dy;
        int e2;
        int ex;
        int sx;
        int sy;
        out_item_t px;
        if (cmd.kind == KIND_START) begin
            dx = int'($signed(cmd.end_x)) - int'($signed(cmd.start_x));
            dy = int'($signed(cmd.end_y)) - int'($signed(cmd.start_y));
            line_x = cmd.start_x;
            line_y = cmd.start_y;
            goal_x = cmd.end_x;
            goal_y = cmd.end_y;
            // zero delta counts as the negative direction
            step_x_neg = !(dx > 0);
            step_y_neg = !(dy > 0);
            span_x = 17'(dx > 0 ? dx : -dx);
            span_y = 17'(dy > 0 ? dy : -dy);
            err_acc = 19'(int'(span_x) - int'(span_y));
            line_live = 1'b1;
            return;
        end
        if (!line_live)
            return;
        px.pixel_x = line_x;
        px.pixel_y = line_y;
        px.last = (line_x == goal_x) && (line_y == goal_y);
        px.inside_res = (line_x >= 0) && (line_y >= 0) &&
                        (int'(line_x) < int'(surf_w)) && (int'(line_y) < int'(surf_h));
        pixels_due.push_back(px);
        if (px.last) begin
            line_live = 1'b0;
        end
        else begin
            sx = int'(span_x);
            sy = int'(span_y);
            ex = int'(err_acc);
            e2 = 2 * ex;
            if (e2 > -sy) begin
                ex -= sy;
                line_x = 16'(int'(line_x) + (step_x_neg ? -1 : 1));
            end
            if (e2 < sx) begin
                ex += sx;
                line_y = 16'(int'(line_y) + (step_y_neg ? -1 : 1));
            end
            err_acc = 19'(ex);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next pending transaction unless idling; a held
    // transaction stays on the port until the block takes it.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full)
                trace_pixel(line_cmd);
            if (!push || !full) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    line_cmd <= pending_cmds.pop_front();
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each popped pixel against the oldest owed one, then
    // decides whether to pop next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : pixel_monitor
        out_item_t due;
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                if (pixels_due.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d", pixel_out.pixel_x,
                           pixel_out.pixel_y);
                    mismatches++;
                end
                else begin
                    due = pixels_due.pop_front();
                    if (pixel_out.pixel_x !== due.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d", due.pixel_x,
                               pixel_out.pixel_x);
                        mismatches++;
                    end
                    if (pixel_out.pixel_y !== due.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d", due.pixel_y,
                               pixel_out.pixel_y);
                        mismatches++;
                    end
                    if (pixel_out.inside_res !== due.inside_res) begin
                        $error("inside_res: expected %0b, got %0b", due.inside_res,
                               pixel_out.inside_res);
                        mismatches++;
                    end
                    if (pixel_out.last !== due.last) begin
                        $error("last: expected %0b, got %0b", due.last, pixel_out.last);
                        mismatches++;
                    end
                end
            end
            pop <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up and raises full
    initial begin : rx_hold_ctl
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("bresenham_line_stepper_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // coordinates biased towards zero and the surface edges so that the
    // inside flag flips often
    function automatic logic signed [15:0] rand_coord(input int extent);
        int v;
        case ($urandom_range(3))
            0:       v = int'($urandom_range(65535));
            1:       v = int'($urandom_range(40)) - 20;
            2:       v = extent + int'($urandom_range(40)) - 20;
            default: v = int'($urandom_range(1100));
        endcase
        return 16'(v);
    endfunction

    // far end at start + d, mirrored when that leaves the coordinate range
    function automatic logic signed [15:0] far_end(input logic signed [15:0] s, input int d);
        int e;
        e = int'(s) + d;
        if (e > 32767 || e < -32768)
            e = int'(s) - d;
        return 16'(e);
    endfunction

    function automatic void add_step();
        in_item_t cmd;
        cmd.kind = KIND_STEP;
        cmd.start_x = rnd16();
        cmd.start_y = rnd16();
        cmd.end_x = rnd16();
        cmd.end_y = rnd16();
        pending_cmds.push_back(cmd);
    endfunction

    function automatic void add_line(input int x0, y0, x1, y1, input int nsteps);
        in_item_t cmd;
        cmd.kind = KIND_START;
        cmd.start_x = 16'(x0);
        cmd.start_y = 16'(y0);
        cmd.end_x = 16'(x1);
        cmd.end_y = 16'(y1);
        pending_cmds.push_back(cmd);
        repeat (nsteps) add_step();
    endfunction

    // mostly complete lines with random content; some cut short by a fresh
    // start, some with full-range endpoints, and the odd stray step
    task automatic queue_random(input int n);
        int added;
        int pick;
        int span;
        int dx;
        int dy;
        int nsteps;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                nsteps = $urandom_range(3);
                add_line(rnd16(), rnd16(), rnd16(), rnd16(), nsteps);
            end
            else begin
                span = ($urandom_range(49) == 0) ? 300 : 12;
                dx = int'($urandom_range(2 * span)) - span;
                dy = int'($urandom_range(2 * span)) - span;
                case ($urandom_range(9))
                    0:       dy = 0;
                    1:       dx = 0;
                    2:       dy = ($urandom_range(1) != 0) ? dx : -dx;
                    default: ;
                endcase
                sx = rand_coord(int'(surf_w));
                sy = rand_coord(int'(surf_h));
                ex = far_end(sx, dx);
                ey = far_end(sy, dy);
                dx = int'(ex) - int'(sx);
                dy = int'(ey) - int'(sy);
                nsteps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                          (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy)) + 1;
                // broken line: dropped part-way by the next start
                if (pick >= 88)
                    nsteps = $urandom_range(nsteps - 1);
                add_line(sx, sy, ex, ey, nsteps);
                if ($urandom_range(9) == 0)
                    add_step();
            end
            added += nsteps + 1;
        end
    endtask

    task automatic write_reg(input logic [REG_ADDR_BITS-1:0] idx,
                             input logic [REG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SURFACE_WIDTH)
            surf_w = val;
        else
            surf_h = val;
    endtask

    // wait until every transaction is taken and every pixel has come back,
    // then give trailing starts and ignored steps time to clear the block
    task automatic drain();
        while (pending_cmds.size() != 0 || push || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [REG_DATA_BITS-1:0] w, h,
                             input int send_pct, recv_pct, n, input bit squeeze);
        write_reg(REG_SURFACE_WIDTH, w);
        write_reg(REG_SURFACE_HEIGHT, h);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        if (squeeze)
            hold_go = 1'b1;
        queue_random(n);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset surface 1024 x 768, no idling
        add_step();                                  // no line yet: ignored
        add_line(5, 5, 5, 5, 2);                     // single pixel, then ignored
        add_line(-32768, -32768, 32767, 32767, 2);   // extremes, cut short
        add_line(32767, 32767, -32768, -32768, 2);   // start over a live line
        add_line(1022, 766, 1024, 768, 3);           // walks off the surface corner
        add_line(-1, 2, 1, -2, 5);                   // steep, crosses zero
        drain();

        run_phase(15'd16,    15'd10,    0,  0,  70, 1'b0);
        run_phase(15'd32767, 15'd32767, 67, 0,  70, 1'b0);
        run_phase(15'd0,     15'd20,    0,  67, 70, 1'b0);
        run_phase(15'd40,    15'd0,     33, 33, 70, 1'b0);
        run_phase(15'd1,     15'd1,     0,  0,  40, 1'b1);
        run_phase(15'd900,   15'd700,   33, 33, 70, 1'b0);

        if (!empty) begin
            $error("pixel left in the block with nothing owed");
            mismatches++;
        end
        if (mismatches == 0)
            $display("bresenham_line_stepper_top test passed");
        else
            $display("bresenham_line_stepper_top test failed");
        $finish;
    end

endmodule

>>> files.f
sv/bls_pkg.sv
sv/bls_fifo.sv
sv/bls_front.sv
sv/bls_back.sv
sv/bresenham_line_stepper_top.sv
tb/tb_top.sv
